// ----- src/fdd_pkg.sv -----
package fdd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int RESULT_BITS = 32;
	localparam int INV_W = 24;
	localparam int FRAC_BITS = 16;

	localparam int TDATA_IN_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int TDATA_OUT_W = ((RESULT_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = INV_W;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP = 1'd1;
	localparam logic [INV_W-1:0] INV_STEP_RESET = 24'd655360;

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_FWD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CEN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BWD = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SHORT = 2'd3;

	// weighted sums need at most 7 extra magnitude bits (coefficient weight 128)
	localparam int SUM_W = SAMPLE_BITS + 8;
	localparam int MAG_W = SAMPLE_BITS + 7;
	localparam int PROD_W = MAG_W + INV_W;
	localparam int SH2 = FRAC_BITS + 1;
	localparam int SH12 = FRAC_BITS + 2;
	localparam int RND2 = 1 << FRAC_BITS;
	localparam int RND12 = 3 << (FRAC_BITS + 1);
	localparam int QW = PROD_W + 1 - SH2;
	localparam int TW = PROD_W + 1 - SH12;
	localparam int RECIP_W = TW + 1;
	localparam logic [RECIP_W-1:0] DIV3_RECIP =
		RECIP_W'(((64'd1 << (TW + 2)) + 64'd2) / 64'd3);
	localparam int CW = ((QW > RESULT_BITS) ? QW : RESULT_BITS) + 1;
	localparam logic [CW-1:0] SAT_POS = CW'((64'd1 << (RESULT_BITS - 1)) - 64'd1);
	localparam logic [CW-1:0] SAT_NEG = CW'(64'd1 << (RESULT_BITS - 1));

	localparam int WIN_DEPTH = 6;
	localparam int CNT_W = 3;
	localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;
	localparam logic [CNT_W-1:0] CNT_MIN3 = 3'd3;
	localparam logic [CNT_W-1:0] CNT_MIN5 = 3'd6;

	localparam int NUM_JOBS = 10;
	localparam int JOB_W = 4;
	localparam logic [JOB_W-1:0] J3_FWD = 4'd0;
	localparam logic [JOB_W-1:0] J3_CEN = 4'd1;
	localparam logic [JOB_W-1:0] J3_BWD = 4'd2;
	localparam logic [JOB_W-1:0] J5_FWD_A = 4'd3;
	localparam logic [JOB_W-1:0] J5_FWD_B = 4'd4;
	localparam logic [JOB_W-1:0] J5_CEN_A = 4'd5;
	localparam logic [JOB_W-1:0] J5_CEN_B = 4'd6;
	localparam logic [JOB_W-1:0] J5_BWD_A = 4'd7;
	localparam logic [JOB_W-1:0] J5_BWD_B = 4'd8;
	localparam logic [JOB_W-1:0] J_SHORT = 4'd9;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		sum_t sum;
		logic five;
		logic [KIND_W-1:0] kind;
		logic last;
	} job_t;

endpackage

// ----- src/fdd_front.sv -----
module fdd_front (
	input  logic clk,
	input  logic arst_n,
	input  logic s_valid,
	output logic s_ready,
	input  fdd_pkg::sample_t sample,
	input  logic last_sample,
	input  logic five_point_mode,
	output logic push,
	output fdd_pkg::job_t job,
	input  logic full
);
	import fdd_pkg::*;

	function automatic sum_t fwd3(sample_t a, sample_t b, sample_t c);
		return sum_t'(-3 * sum_t'(a) + 4 * sum_t'(b) - sum_t'(c));
	endfunction

	function automatic sum_t cen3(sample_t a, sample_t c);
		return sum_t'(sum_t'(c) - sum_t'(a));
	endfunction

	function automatic sum_t bwd3(sample_t a, sample_t b, sample_t c);
		return sum_t'(sum_t'(a) - 4 * sum_t'(b) + 3 * sum_t'(c));
	endfunction

	function automatic sum_t fwd5(sample_t a, sample_t b, sample_t c, sample_t d, sample_t e);
		return sum_t'(-25 * sum_t'(a) + 48 * sum_t'(b) - 36 * sum_t'(c)
			+ 16 * sum_t'(d) - 3 * sum_t'(e));
	endfunction

	function automatic sum_t cen5(sample_t a, sample_t b, sample_t d, sample_t e);
		return sum_t'(sum_t'(a) - 8 * sum_t'(b) + 8 * sum_t'(d) - sum_t'(e));
	endfunction

	function automatic sum_t bwd5(sample_t a, sample_t b, sample_t c, sample_t d, sample_t e);
		return sum_t'(3 * sum_t'(a) - 16 * sum_t'(b) + 36 * sum_t'(c)
			- 48 * sum_t'(d) + 25 * sum_t'(e));
	endfunction

	sample_t w_q [WIN_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_JOBS-1:0] pend_q;

	logic accept;
	logic [CNT_W-1:0] cnt_nxt;
	logic [NUM_JOBS-1:0] pend_new;
	logic [JOB_W-1:0] sel;
	logic [NUM_JOBS-1:0] sel_mask;

	assign s_ready = (pend_q == '0);
	assign accept = s_valid && s_ready;
	assign cnt_nxt = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign push = (pend_q != '0) && !full;

	always_comb begin
		pend_new = '0;
		if (!five_point_mode) begin
			if (cnt_nxt == CNT_MIN3)
				pend_new[J3_FWD] = 1'b1;
			if (cnt_nxt >= CNT_MIN3)
				pend_new[J3_CEN] = 1'b1;
			if (last_sample) begin
				if (cnt_nxt >= CNT_MIN3)
					pend_new[J3_BWD] = 1'b1;
				else
					pend_new[J_SHORT] = 1'b1;
			end
		end else begin
			if (cnt_nxt == CNT_MIN5) begin
				pend_new[J5_FWD_A] = 1'b1;
				pend_new[J5_FWD_B] = 1'b1;
				pend_new[J5_CEN_A] = 1'b1;
			end
			if (cnt_nxt >= CNT_MIN5)
				pend_new[J5_CEN_B] = 1'b1;
			if (last_sample) begin
				if (cnt_nxt >= CNT_MIN5) begin
					pend_new[J5_BWD_A] = 1'b1;
					pend_new[J5_BWD_B] = 1'b1;
				end else begin
					pend_new[J_SHORT] = 1'b1;
				end
			end
		end
	end

	// lowest pending job goes first: bit order is emission order
	always_comb begin
		sel = J_SHORT;
		for (int i = NUM_JOBS - 1; i >= 0; i--) begin
			if (pend_q[i])
				sel = JOB_W'(i);
		end
		sel_mask = NUM_JOBS'(1) << sel;
	end

	always_comb begin
		job.five = 1'b1;
		job.last = 1'b0;
		case (sel)
			J3_FWD: begin
				job.sum = fwd3(w_q[2], w_q[1], w_q[0]);
				job.kind = KIND_FWD;
				job.five = 1'b0;
			end
			J3_CEN: begin
				job.sum = cen3(w_q[2], w_q[0]);
				job.kind = KIND_CEN;
				job.five = 1'b0;
			end
			J3_BWD: begin
				job.sum = bwd3(w_q[2], w_q[1], w_q[0]);
				job.kind = KIND_BWD;
				job.five = 1'b0;
				job.last = 1'b1;
			end
			J5_FWD_A: begin
				job.sum = fwd5(w_q[5], w_q[4], w_q[3], w_q[2], w_q[1]);
				job.kind = KIND_FWD;
			end
			J5_FWD_B: begin
				job.sum = fwd5(w_q[4], w_q[3], w_q[2], w_q[1], w_q[0]);
				job.kind = KIND_FWD;
			end
			J5_CEN_A: begin
				job.sum = cen5(w_q[5], w_q[4], w_q[2], w_q[1]);
				job.kind = KIND_CEN;
			end
			J5_CEN_B: begin
				job.sum = cen5(w_q[4], w_q[3], w_q[1], w_q[0]);
				job.kind = KIND_CEN;
			end
			J5_BWD_A: begin
				job.sum = bwd5(w_q[5], w_q[4], w_q[3], w_q[2], w_q[1]);
				job.kind = KIND_BWD;
			end
			J5_BWD_B: begin
				job.sum = bwd5(w_q[4], w_q[3], w_q[2], w_q[1], w_q[0]);
				job.kind = KIND_BWD;
				job.last = 1'b1;
			end
			J_SHORT: begin
				job.sum = '0;
				job.kind = KIND_SHORT;
				job.last = 1'b1;
			end
			default: begin
				job.sum = '0;
				job.kind = KIND_SHORT;
				job.last = 1'b1;
			end
		endcase
	end

	// window taps older than the sequence count are never used, so no clear
	always_ff @(posedge clk) begin
		if (accept) begin
			w_q[0] <= sample;
			for (int i = 1; i < WIN_DEPTH; i++)
				w_q[i] <= w_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pend_q <= '0;
		end else if (accept) begin
			cnt_q <= last_sample ? '0 : cnt_nxt;
			pend_q <= pend_new;
		end else if (push) begin
			pend_q <= pend_q & ~sel_mask;
		end
	end

endmodule

// ----- src/fdd_fifo.sv -----
module fdd_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  fdd_pkg::job_t wr_job,
	output logic full,
	input  logic pop,
	output fdd_pkg::job_t rd_job,
	output logic empty
);
	import fdd_pkg::*;

	job_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/fdd_back.sv -----
module fdd_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [fdd_pkg::INV_W-1:0] inv_step,
	input  fdd_pkg::job_t head,
	input  logic empty,
	output logic pop,
	output logic m_valid,
	input  logic m_ready,
	output logic [fdd_pkg::RESULT_BITS-1:0] derivative,
	output logic [fdd_pkg::KIND_W-1:0] kind,
	output logic last_result
);
	import fdd_pkg::*;

	logic en;

	logic vld_s1, neg_s1, five_s1, last_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [MAG_W-1:0] mag_s1;

	logic vld_s2, neg_s2, five_s2, last_s2;
	logic [KIND_W-1:0] kind_s2;
	logic [PROD_W-1:0] prod_s2;

	logic vld_s3, neg_s3, five_s3, last_s3;
	logic [KIND_W-1:0] kind_s3;
	logic [QW-1:0] q_s3;

	logic vld_s4, neg_s4, five_s4, last_s4;
	logic [KIND_W-1:0] kind_s4;
	logic [QW-1:0] q_s4;
	logic [TW+RECIP_W-1:0] p3_s4;

	logic out_vld_q, last_q;
	logic [KIND_W-1:0] kind_q;
	logic [RESULT_BITS-1:0] deriv_q;

	sum_t head_neg;
	logic [MAG_W-1:0] head_mag;
	logic [PROD_W:0] r2, r12;
	logic [QW-1:0] q3_nxt;
	logic [QW-1:0] q_fin;
	logic [CW-1:0] qe, qs;

	assign en = !out_vld_q || m_ready;
	assign pop = en && !empty;

	assign head_neg = -head.sum;
	assign head_mag = MAG_W'(head.sum[SUM_W-1] ? head_neg : head.sum);

	// round half up on magnitude; five-point divides by 3 * 2^18 in two steps
	assign r2 = {1'b0, prod_s2} + (PROD_W + 1)'(RND2);
	assign r12 = {1'b0, prod_s2} + (PROD_W + 1)'(RND12);
	assign q3_nxt = five_s2 ? QW'(r12 >> SH12) : QW'(r2 >> SH2);

	assign q_fin = five_s4 ? QW'(p3_s4 >> (TW + 2)) : q_s4;
	assign qe = CW'(q_fin);

	always_comb begin
		if (neg_s4)
			qs = (qe > SAT_NEG) ? SAT_NEG : qe;
		else
			qs = (qe > SAT_POS) ? SAT_POS : qe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= !empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= head_mag;
			neg_s1 <= head.sum[SUM_W-1];
			five_s1 <= head.five;
			kind_s1 <= head.kind;
			last_s1 <= head.last;

			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(inv_step);
			neg_s2 <= neg_s1;
			five_s2 <= five_s1;
			kind_s2 <= kind_s1;
			last_s2 <= last_s1;

			q_s3 <= q3_nxt;
			neg_s3 <= neg_s2;
			five_s3 <= five_s2;
			kind_s3 <= kind_s2;
			last_s3 <= last_s2;

			q_s4 <= q_s3;
			p3_s4 <= (TW + RECIP_W)'(q_s3[TW-1:0]) * (TW + RECIP_W)'(DIV3_RECIP);
			neg_s4 <= neg_s3;
			five_s4 <= five_s3;
			kind_s4 <= kind_s3;
			last_s4 <= last_s3;

			deriv_q <= RESULT_BITS'(neg_s4 ? -qs : qs);
			kind_q <= kind_s4;
			last_q <= last_s4;
		end
	end

	assign m_valid = out_vld_q;
	assign derivative = deriv_q;
	assign kind = kind_q;
	assign last_result = last_q;

endmodule

// ----- src/finite_difference_derivative.sv -----
// Finite-difference derivative of a sample stream, with 3-point or 5-point
// formulas (forward at the start, centered inside, backward at the end).
// A sample is taken only when none of its predecessor's results are pending;
// it triggers 0 to 6 results, issued one weighted sum per cycle into a
// 4-entry queue while that is not full. A result taken from the queue passes
// the magnitude, product, quotient, divide-by-3 and output registers (two
// registered multiplies, rounding and saturation). Results are saturated
// round(sum * inv_step / (2 or 12) / 2^16), half away from zero.
// Write five_point_mode and inv_step only while the block is idle.
module finite_difference_derivative (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [fdd_pkg::TDATA_IN_W-1:0] s_tdata,   // [15:0] sample
	input  logic s_tlast,                             // last_sample
	output logic m_tvalid,
	input  logic m_tready,
	output logic [fdd_pkg::TDATA_OUT_W-1:0] m_tdata,  // [31:0] derivative
	output logic [fdd_pkg::KIND_W-1:0] m_tuser,       // [1:0] kind
	output logic m_tlast,                             // last_result
	input  logic cfg_we,
	input  logic [fdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fdd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fdd_pkg::*;

	logic mode_q;
	logic [INV_W-1:0] inv_step_q;

	logic push, full, pop, empty;
	job_t wr_job, rd_job;
	logic [RESULT_BITS-1:0] derivative;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			inv_step_q <= INV_STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[0];
				CFG_INV_STEP: inv_step_q <= cfg_data[INV_W-1:0];
				default: mode_q <= mode_q;
			endcase
		end
	end

	fdd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_valid         (s_tvalid),
		.s_ready         (s_tready),
		.sample          (sample_t'(s_tdata[SAMPLE_BITS-1:0])),
		.last_sample     (s_tlast),
		.five_point_mode (mode_q),
		.push            (push),
		.job             (wr_job),
		.full            (full)
	);

	fdd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	fdd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.inv_step    (inv_step_q),
		.head        (rd_job),
		.empty       (empty),
		.pop         (pop),
		.m_valid     (m_tvalid),
		.m_ready     (m_tready),
		.derivative  (derivative),
		.kind        (m_tuser),
		.last_result (m_tlast)
	);

	assign m_tdata = TDATA_OUT_W'(derivative);

endmodule

// ----- src/fdd_checker.sv -----
module fdd_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [fdd_pkg::TDATA_OUT_W-1:0] m_tdata,
	input logic [fdd_pkg::KIND_W-1:0] m_tuser,
	input logic m_tlast
);
	import fdd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_SHORT |-> m_tlast && m_tdata == '0)
		else $error("too-short result must be zero and last");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_BWD || m_tuser == KIND_SHORT)
		else $error("last result must be backward or too-short");

	a_mid_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_FWD || m_tuser == KIND_CEN) |-> !m_tlast)
		else $error("forward or centered result marked last");

endmodule

bind finite_difference_derivative fdd_checker u_fdd_checker (.*);

// ----- bench/fdd_check.sv -----
`timescale 1ns / 100ps

module fdd_check (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [fdd_pkg::TDATA_IN_W-1:0] s_tdata,
	input  logic s_tlast,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [fdd_pkg::TDATA_OUT_W-1:0] m_tdata,
	input  logic [fdd_pkg::KIND_W-1:0] m_tuser,
	input  logic m_tlast,
	input  logic cfg_we,
	input  logic [fdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fdd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int fail_count,
	output int pending,
	output int checked,
	output int short_count
);
	import fdd_pkg::*;

	typedef struct {
		logic [RESULT_BITS-1:0] derivative;
		logic [KIND_W-1:0] kind;
		logic last;
	} deriv_t;

	deriv_t expected_derivs[$];

	logic five_mode;
	logic [INV_W-1:0] inv_reg;
	sample_t hist[WIN_DEPTH];
	int unsigned run_len;

	task automatic report(string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	// round half away from zero of sum*inv_step/(denom*2^16), saturated
	function automatic logic [RESULT_BITS-1:0] scaled(longint sum, longint unsigned denom);
		longint unsigned mag;
		longint unsigned den;
		longint unsigned q;
		longint unsigned maxpos;
		maxpos = (64'd1 << (RESULT_BITS - 1)) - 64'd1;
		mag = (sum < 0) ? 64'd0 - sum : sum;
		den = denom << FRAC_BITS;
		q = (mag * inv_reg + (den >> 1)) / den;
		if (sum < 0) begin
			if (q > maxpos + 1)
				q = maxpos + 1;
			return RESULT_BITS'(64'd0 - q);
		end
		if (q > maxpos)
			q = maxpos;
		return RESULT_BITS'(q);
	endfunction

	task automatic add(logic [RESULT_BITS-1:0] d, logic [KIND_W-1:0] k, logic l);
		deriv_t r;
		r.derivative = d;
		r.kind = k;
		r.last = l;
		expected_derivs = {expected_derivs, r};
	endtask

	task automatic derive_sample(sample_t smp, logic lst);
		longint w[WIN_DEPTH];
		int unsigned c;
		c = (run_len < 7) ? run_len + 1 : 7;
		for (int i = WIN_DEPTH - 1; i > 0; i--)
			hist[i] = hist[i-1];
		hist[0] = smp;
		for (int i = 0; i < WIN_DEPTH; i++)
			w[i] = longint'(hist[i]);
		if (!five_mode) begin
			if (c == 3)
				add(scaled(-3*w[2] + 4*w[1] - w[0], 2), KIND_FWD, 1'b0);
			if (c >= 3)
				add(scaled(w[0] - w[2], 2), KIND_CEN, 1'b0);
			if (lst) begin
				if (c >= 3)
					add(scaled(w[2] - 4*w[1] + 3*w[0], 2), KIND_BWD, 1'b1);
				else
					add('0, KIND_SHORT, 1'b1);
			end
		end else begin
			if (c == 6) begin
				add(scaled(-25*w[5] + 48*w[4] - 36*w[3] + 16*w[2] - 3*w[1], 12), KIND_FWD, 1'b0);
				add(scaled(-25*w[4] + 48*w[3] - 36*w[2] + 16*w[1] - 3*w[0], 12), KIND_FWD, 1'b0);
				add(scaled(w[5] - 8*w[4] + 8*w[2] - w[1], 12), KIND_CEN, 1'b0);
			end
			if (c >= 6)
				add(scaled(w[4] - 8*w[3] + 8*w[1] - w[0], 12), KIND_CEN, 1'b0);
			if (lst) begin
				if (c >= 6) begin
					add(scaled(3*w[5] - 16*w[4] + 36*w[3] - 48*w[2] + 25*w[1], 12),
						KIND_BWD, 1'b0);
					add(scaled(3*w[4] - 16*w[3] + 36*w[2] - 48*w[1] + 25*w[0], 12),
						KIND_BWD, 1'b1);
				end else begin
					add('0, KIND_SHORT, 1'b1);
				end
			end
		end
		if (lst) begin
			for (int i = 0; i < WIN_DEPTH; i++)
				hist[i] = '0;
			run_len = 0;
		end else begin
			run_len = c;
		end
	endtask

	always @(posedge clk) begin
		deriv_t exp_r;
		if (!arst_n) begin
			five_mode = 1'b0;
			inv_reg = INV_STEP_RESET;
			for (int i = 0; i < WIN_DEPTH; i++)
				hist[i] = '0;
			run_len = 0;
			expected_derivs.delete();
			fail_count = 0;
			checked = 0;
			short_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE: five_mode = cfg_data[0];
					CFG_INV_STEP: inv_reg = cfg_data[INV_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				derive_sample(sample_t'(s_tdata[SAMPLE_BITS-1:0]), s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_derivs.size() == 0) begin
					report($sformatf("unexpected transaction derivative=%0d kind=%0d last=%0b",
						$signed(m_tdata[RESULT_BITS-1:0]), m_tuser, m_tlast));
				end else begin
					exp_r = expected_derivs.pop_front();
					if (m_tdata[RESULT_BITS-1:0] !== exp_r.derivative)
						report($sformatf("derivative %0d, expected %0d",
							$signed(m_tdata[RESULT_BITS-1:0]), $signed(exp_r.derivative)));
					if (m_tuser !== exp_r.kind)
						report($sformatf("kind %0d, expected %0d", m_tuser, exp_r.kind));
					if (m_tlast !== exp_r.last)
						report($sformatf("last %0b, expected %0b", m_tlast, exp_r.last));
					checked++;
					if (exp_r.kind == KIND_SHORT)
						short_count++;
				end
			end
		end
		pending <= expected_derivs.size();
	end

endmodule

// ----- bench/tb_finite_difference_derivative.sv -----
`timescale 1ns / 100ps

module tb_finite_difference_derivative;
	import fdd_pkg::*;

	localparam int LIMIT = 400000;
	localparam int SETTLE = 24;
	localparam int ITEMS = 110;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [TDATA_IN_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic [KIND_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int pending_results;
	int results_checked;
	int shorts_checked;

	int cycles;
	int rx_hold;
	bit rx_burst;
	bit tx_burst;
	int samples_sent;
	int sequences_sent;

	finite_difference_derivative dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	fdd_check check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(mismatches),
		.pending(pending_results),
		.checked(results_checked),
		.short_count(shorts_checked)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending_results);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// output back-pressure outside bursts: a random stall after each transaction, plus random idle drops
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			rx_hold = rx_burst ? 0 : $urandom_range(0, 19);
			m_tready <= (rx_hold == 0);
		end else if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= (rx_hold == 0);
		end else begin
			m_tready <= rx_burst || ($urandom_range(0, 3) != 0);
		end
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return sample_t'(16'h7FFF);
			1: return sample_t'(16'h8000);
			2: return '0;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_sample(sample_t smp, bit lst);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TDATA_IN_W'($unsigned(smp));
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		if (lst)
			sequences_sent++;
	endtask

	task automatic send_seq(int len, bit alternate);
		sample_t v;
		for (int i = 0; i < len; i++) begin
			if (alternate)
				v = (i % 2) ? sample_t'(16'h8000) : sample_t'(16'h7FFF);
			else
				v = pick_sample();
			send_sample(v, i == len - 1);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int len;
		bit mode;
		logic [INV_W-1:0] inv;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: too-short runs of one and two samples
		send_seq(1, 1'b0);
		send_seq(2, 1'b1);
		settle();

		// three-point, largest step reciprocal, full-scale swings
		write_reg(CFG_MODE, '0);
		write_reg(CFG_INV_STEP, 24'hFFFFFF);
		send_seq(4, 1'b1);
		settle();

		// five-point: one sample short, then a run that reaches the counter limit
		write_reg(CFG_MODE, CFG_DATA_W'(1));
		send_seq(5, 1'b1);
		send_seq(7, 1'b1);
		settle();

		// zero step reciprocal
		write_reg(CFG_MODE, '0);
		write_reg(CFG_INV_STEP, '0);
		send_seq(3, 1'b0);
		settle();

		// mode switched inside a sequence
		write_reg(CFG_INV_STEP, INV_STEP_RESET);
		write_reg(CFG_MODE, CFG_DATA_W'(1));
		send_sample(pick_sample(), 1'b0);
		send_sample(pick_sample(), 1'b0);
		send_sample(pick_sample(), 1'b0);
		settle();
		write_reg(CFG_MODE, '0);
		send_sample(pick_sample(), 1'b1);
		settle();

		while (samples_sent < ITEMS) begin
			mode = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0: inv = '0;
				1: inv = 24'hFFFFFF;
				2: inv = INV_STEP_RESET;
				3: inv = INV_W'($urandom_range(1, 255));
				default: inv = INV_W'($urandom);
			endcase
			write_reg(CFG_MODE, CFG_DATA_W'(mode));
			write_reg(CFG_INV_STEP, inv);
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			repeat (3) begin
				if (samples_sent < ITEMS) begin
					if ($urandom_range(0, 4) == 0)
						len = $urandom_range(1, mode ? 5 : 2);
					else
						len = mode ? $urandom_range(6, 14) : $urandom_range(3, 12);
					send_seq(len, 1'b0);
				end
			end
			settle();
		end

		tx_burst = 1'b0;
		rx_burst = 1'b0;
		$display("%0d samples in %0d sequences, %0d derivatives checked (%0d too short)",
			samples_sent, sequences_sent, results_checked, shorts_checked);
		$display("both formula sets, inv_step from zero to full scale, stalls on both sides");
		if (mismatches == 0 && pending_results == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
